// ----- src/dhp_pkg.sv -----
package dhp_pkg;

   localparam int NumberBitsDefault = 32;
   localparam int QueueDepth = 2;

   typedef enum logic [3:0] {
      PH_MATCH,
      PH_OLD_START,
      PH_OLD_COUNT,
      PH_PLUS,
      PH_NEW_START,
      PH_NEW_COUNT,
      PH_AT,
      PH_HDR_REST,
      PH_BODY_START,
      PH_BODY_REST,
      PH_PEEK,
      PH_MARK,
      PH_IDLE
   } phase_type;

   typedef enum logic [2:0] {
      EV_HEADER    = 3'd0,
      EV_LINE      = 3'd1,
      EV_NONL      = 3'd2,
      EV_ENDED     = 3'd3,
      EV_MALFORMED = 3'd4,
      EV_TRUNC     = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      LK_REMOVED = 2'd0,
      LK_CONTEXT = 2'd1,
      LK_ADDED   = 2'd2
   } kind_type;

   // byte classes, which with the low digit nibble are all the back end needs to know about a text byte
   typedef enum logic [3:0] {
      CC_DIGIT,
      CC_COMMA,
      CC_SPACE,
      CC_PLUS,
      CC_MINUS,
      CC_AT,
      CC_NL,
      CC_BSLASH,
      CC_CTX,       // '=', tab, NUL
      CC_OTHER
   } class_type;

   typedef struct packed {
      logic       eof;
      class_type  cls;
      logic [3:0] digit;
   } qent_type;

   function automatic class_type classify(input logic [7:0] c);
      class_type r;
      r = CC_OTHER;
      if (c >= 8'h30 && c <= 8'h39) r = CC_DIGIT;
      else case (c)
         8'h2C: r = CC_COMMA;
         8'h20: r = CC_SPACE;
         8'h2B: r = CC_PLUS;
         8'h2D: r = CC_MINUS;
         8'h40: r = CC_AT;
         8'h0A: r = CC_NL;
         8'h5C: r = CC_BSLASH;
         8'h3D, 8'h09, 8'h00: r = CC_CTX;
         default: r = CC_OTHER;
      endcase
      return r;
   endfunction

endpackage

// ----- src/dhp_if.sv -----
interface dhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;
   modport source (output valid, data_byte, end_of_input, input ready);
   modport sink (input valid, data_byte, end_of_input, output ready);
endinterface

interface dhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [1:0]  line_kind;
   logic [31:0] old_start;
   logic [31:0] old_count;
   logic [31:0] new_start;
   logic [31:0] new_count;
   logic        last;
   modport source (output valid, event_res, line_kind, old_start, old_count,
                   new_start, new_count, last, input ready);
   modport sink (input valid, event_res, line_kind, old_start, old_count,
                 new_start, new_count, last, output ready);
endinterface

// ----- src/dhp_front.sv -----
module dhp_front
   import dhp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  logic [7:0] in_byte,
   input  logic     in_eof,
   output logic     q_valid,
   input  logic     q_pop,
   output qent_type q_head
);
   qent_type   mem_ff [QueueDepth];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   qent_type   ent;

   assign in_ready = (cnt_ff != 2'(QueueDepth));
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_head   = mem_ff[rptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   always_comb begin
      ent.eof   = in_eof;
      ent.cls   = classify(in_byte);
      ent.digit = in_byte[3:0];
      wptr_in   = push ? ~wptr_ff : wptr_ff;
      rptr_in   = pop ? ~rptr_ff : rptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) mem_ff[wptr_ff] <= ent;
   end
endmodule

// ----- src/dhp_back.sv -----
module dhp_back
   import dhp_pkg::*;
#(
   parameter int NUMBER_BITS = NumberBitsDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   output logic     q_pop,
   input  qent_type q_head,
   dhp_rsp_if.source rsp
);
   localparam int N = NUMBER_BITS;
   localparam logic [N+4:0] MaxWide = (N+5)'((((N+5)'(1)) << N) - 1);
   localparam logic [N:0]   MaxN1   = {1'b0, {N{1'b1}}};
   localparam logic [N+1:0] MaxN2   = {2'b00, {N{1'b1}}};
   localparam logic [N:0]   Sentinel = {1'b1, {N{1'b0}}};

   phase_type  phase_ff, phase_in;
   logic [1:0] mpos_ff, mpos_in;
   logic [N:0] acc_ff, acc_in;
   logic       seen_ff, seen_in;
   logic [N-1:0] os_ff, os_in, oc_ff, oc_in, ns_ff, ns_in, nc_ff, nc_in;
   logic [N-1:0] orem_ff, orem_in, nrem_ff, nrem_in;
   kind_type   kind_ff, kind_in;
   logic       peek_ff, peek_in;

   logic        ov_ff, ov_in;
   event_type   oev_ff, oev_in;
   kind_type    okind_ff, okind_in;
   logic [31:0] oos_ff, oos_in, ooc_ff, ooc_in, ons_ff, ons_in, onc_ff, onc_in;

   phase_type  eff;
   logic       emit, do_at, do_done, num_ok, c_digit;
   event_type  ev;
   kind_type   kd;
   logic [N+4:0] acc_t;
   logic [N-1:0] num_val;
   logic [N:0]   sum_o, sum_n;
   logic [N+1:0] sum_c;

   assign q_pop     = q_valid && (!ov_ff || rsp.ready);
   assign rsp.valid     = ov_ff;
   assign rsp.event_res = oev_ff;
   assign rsp.line_kind = okind_ff;
   assign rsp.old_start = oos_ff;
   assign rsp.old_count = ooc_ff;
   assign rsp.new_start = ons_ff;
   assign rsp.new_count = onc_ff;
   assign rsp.last      = 1'b1;

   always_comb begin
      phase_in = phase_ff; mpos_in = mpos_ff; acc_in = acc_ff; seen_in = seen_ff;
      os_in = os_ff; oc_in = oc_ff; ns_in = ns_ff; nc_in = nc_ff;
      orem_in = orem_ff; nrem_in = nrem_ff; kind_in = kind_ff; peek_in = peek_ff;
      emit = 1'b0; do_at = 1'b0; do_done = 1'b0;
      ev = EV_HEADER; kd = LK_REMOVED;
      sum_o = '0; sum_n = '0; sum_c = '0;
      c_digit = (q_head.cls == CC_DIGIT);
      // decimal step: acc*10 + d, saturating to the sentinel above the limit
      acc_t = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + (N+5)'(q_head.digit);
      num_ok  = seen_ff && !acc_ff[N];
      num_val = acc_ff[N-1:0];

      // a peeked line that is not a marker is the start of the next line
      eff = phase_ff;
      if (phase_ff == PH_PEEK && q_head.cls != CC_BSLASH)
         eff = (orem_ff == '0 && nrem_ff == '0) ? PH_MATCH : PH_BODY_START;

      if (q_valid && q_pop && phase_ff != PH_IDLE) begin
         if (q_head.eof) begin
            emit = 1'b1;
            phase_in = PH_IDLE;
            if (phase_ff == PH_MATCH) ev = EV_ENDED;
            else if (phase_ff <= PH_AT) ev = EV_MALFORMED;
            else if (orem_ff < N'(3) && nrem_ff < N'(3)) ev = EV_ENDED;
            else ev = EV_TRUNC;
         end else if (c_digit && (eff == PH_OLD_START || eff == PH_OLD_COUNT ||
                                  eff == PH_NEW_START || eff == PH_NEW_COUNT)) begin
            acc_in  = (acc_ff[N] || acc_t > MaxWide) ? Sentinel : acc_t[N:0];
            seen_in = 1'b1;
         end else begin
            phase_in = eff;
            if (eff == PH_OLD_START || eff == PH_OLD_COUNT ||
                eff == PH_NEW_START || eff == PH_NEW_COUNT) begin
               acc_in  = '0;
               seen_in = 1'b0;
            end
            case (eff)
               PH_MATCH: begin
                  if ((mpos_ff <= 2'd1 && q_head.cls == CC_AT) ||
                      (mpos_ff == 2'd2 && q_head.cls == CC_SPACE) ||
                      (mpos_ff == 2'd3 && q_head.cls == CC_MINUS)) begin
                     mpos_in = mpos_ff + 2'd1;
                     if (mpos_ff == 2'd3) phase_in = PH_OLD_START;
                  end else begin
                     mpos_in = 2'd0; emit = 1'b1; ev = EV_ENDED; phase_in = PH_IDLE;
                  end
               end
               PH_OLD_START, PH_OLD_COUNT: begin
                  if (!num_ok) begin
                     emit = 1'b1; ev = EV_MALFORMED; phase_in = PH_IDLE;
                  end else begin
                     if (eff == PH_OLD_START) begin
                        os_in = num_val;
                        oc_in = N'(1);
                     end else begin
                        oc_in = num_val;
                     end
                     if (eff == PH_OLD_START && q_head.cls == CC_COMMA)
                        phase_in = PH_OLD_COUNT;
                     else if (q_head.cls == CC_SPACE) phase_in = PH_PLUS;
                     else if (q_head.cls == CC_PLUS) phase_in = PH_NEW_START;
                     else begin
                        emit = 1'b1; ev = EV_MALFORMED; phase_in = PH_IDLE;
                     end
                  end
               end
               PH_PLUS: begin
                  if (q_head.cls == CC_PLUS) phase_in = PH_NEW_START;
                  else begin
                     emit = 1'b1; ev = EV_MALFORMED; phase_in = PH_IDLE;
                  end
               end
               PH_NEW_START, PH_NEW_COUNT: begin
                  if (!num_ok) begin
                     emit = 1'b1; ev = EV_MALFORMED; phase_in = PH_IDLE;
                  end else begin
                     if (eff == PH_NEW_START) begin
                        ns_in = num_val;
                        nc_in = N'(1);
                     end else begin
                        nc_in = num_val;
                     end
                     if (eff == PH_NEW_START && q_head.cls == CC_COMMA)
                        phase_in = PH_NEW_COUNT;
                     else if (q_head.cls == CC_SPACE) phase_in = PH_AT;
                     else do_at = 1'b1;
                  end
               end
               PH_AT: do_at = 1'b1;
               PH_HDR_REST, PH_MARK: begin
                  if (q_head.cls == CC_NL) begin
                     mpos_in = 2'd0;
                     phase_in = (orem_ff == '0 && nrem_ff == '0) ? PH_MATCH
                                                                : PH_BODY_START;
                  end
               end
               PH_BODY_START: begin
                  emit = 1'b1;
                  if (q_head.cls == CC_MINUS) kd = LK_REMOVED;
                  else if (q_head.cls == CC_PLUS) kd = LK_ADDED;
                  else kd = LK_CONTEXT;
                  if (!(q_head.cls == CC_MINUS || q_head.cls == CC_PLUS ||
                        q_head.cls == CC_SPACE || q_head.cls == CC_CTX ||
                        q_head.cls == CC_NL) ||
                      (kd != LK_ADDED && orem_ff == '0) ||
                      (kd != LK_REMOVED && nrem_ff == '0)) begin
                     ev = EV_MALFORMED; kd = LK_REMOVED; phase_in = PH_IDLE;
                  end else begin
                     ev = EV_LINE;
                     if (kd != LK_ADDED) orem_in = orem_ff - N'(1);
                     if (kd != LK_REMOVED) nrem_in = nrem_ff - N'(1);
                     kind_in = kd;
                     peek_in = (kd == LK_REMOVED && orem_in == '0) ||
                               (kd == LK_ADDED && nrem_in == '0);
                     if (q_head.cls == CC_NL) do_done = 1'b1;
                     else phase_in = PH_BODY_REST;
                  end
               end
               PH_BODY_REST: if (q_head.cls == CC_NL) do_done = 1'b1;
               PH_PEEK: begin
                  // only a backslash gets here
                  phase_in = PH_MARK;
                  if (kind_ff == LK_ADDED) begin
                     emit = 1'b1; ev = EV_NONL;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
            if (do_done) begin
               if (peek_in) begin
                  peek_in = 1'b0; phase_in = PH_PEEK;
               end else begin
                  mpos_in = 2'd0;
                  phase_in = (orem_in == '0 && nrem_in == '0) ? PH_MATCH
                                                              : PH_BODY_START;
               end
            end
            if (do_at) begin
               sum_o = {1'b0, os_in} + {1'b0, oc_in};
               sum_n = {1'b0, ns_in} + {1'b0, nc_in};
               sum_c = {2'b00, oc_in} + {2'b00, nc_in} + (N+2)'(1);
               emit = 1'b1;
               if (q_head.cls != CC_AT || sum_o >= MaxN1 || sum_n >= MaxN1 ||
                   sum_c >= MaxN2) begin
                  ev = EV_MALFORMED; phase_in = PH_IDLE;
               end else begin
                  ev = EV_HEADER;
                  if (oc_in == '0) os_in = os_in + N'(1);
                  orem_in = oc_in;
                  nrem_in = nc_in;
                  phase_in = PH_HDR_REST;
               end
            end
         end
      end

      ov_in = ov_ff && !rsp.ready;
      oev_in = oev_ff; okind_in = okind_ff;
      oos_in = oos_ff; ooc_in = ooc_ff; ons_in = ons_ff; onc_in = onc_ff;
      if (emit) begin
         ov_in = 1'b1;
         oev_in = ev;
         okind_in = kd;
         oos_in = (ev == EV_HEADER) ? 32'(os_in) : 32'd0;
         ooc_in = (ev == EV_HEADER) ? 32'(oc_in) : 32'd0;
         ons_in = (ev == EV_HEADER) ? 32'(ns_in) : 32'd0;
         onc_in = (ev == EV_HEADER) ? 32'(nc_in) : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MATCH; mpos_ff <= 2'd0; acc_ff <= '0; seen_ff <= 1'b0;
         os_ff <= '0; oc_ff <= '0; ns_ff <= '0; nc_ff <= '0;
         orem_ff <= '0; nrem_ff <= '0; kind_ff <= LK_REMOVED; peek_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; mpos_ff <= mpos_in; acc_ff <= acc_in; seen_ff <= seen_in;
         os_ff <= os_in; oc_ff <= oc_in; ns_ff <= ns_in; nc_ff <= nc_in;
         orem_ff <= orem_in; nrem_ff <= nrem_in; kind_ff <= kind_in; peek_ff <= peek_in;
         ov_ff <= ov_in;
      end
      oev_ff <= oev_in; okind_ff <= okind_in;
      oos_ff <= oos_in; ooc_ff <= ooc_in; ons_ff <= ons_in; onc_ff <= onc_in;
   end
endmodule

// ----- src/diff_hunk_stream_parser_top.sv -----
// An item that causes an event has it valid on rsp_ch once it has passed a queue
// entry and then the parser step into the result register.
// Throughput: one item per cycle, set by the parser step, while the result register is empty or rsp_ch is ready.
// Synchronous active-high reset clears the queue, parser state and result valid;
// after an ended, malformed or truncated event the parser stays halted until reset.
module diff_hunk_stream_parser_top
   import dhp_pkg::*;
#(
   parameter int NUMBER_BITS = NumberBitsDefault
) (
   input logic clock,
   input logic reset,
   dhp_req_if.sink   req_ch,
   dhp_rsp_if.source rsp_ch
);
   logic     q_valid, q_pop;
   qent_type q_head;

   dhp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .in_byte  (req_ch.data_byte),
      .in_eof   (req_ch.end_of_input),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_head   (q_head)
   );

   dhp_back #(.NUMBER_BITS(NUMBER_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .rsp     (rsp_ch)
   );
endmodule
